// ----- src/bad_block_table_decoder_unit_macros.svh -----
`ifndef BAD_BLOCK_TABLE_DECODER_UNIT_MACROS_SVH
`define BAD_BLOCK_TABLE_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define BBTD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbtd assertion failed");

// next-cycle implication
`define BBTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbtd assertion failed");

`endif

// ----- src/bbtd_pkg.sv -----
`default_nettype none

package bbtd_pkg;

    localparam int STORE_BLOCKS_DEF = 8192;

    localparam int BPB_W      = 4;
    localparam int RSV_W      = 8;
    localparam int BASE_W     = 11;
    localparam int TBL_W      = 14;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 13;
    localparam int CNT_W      = 14;
    localparam int MARK_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int WIDE_IDX_W = 17;

    localparam logic [CNT_W-1:0] CNT_MAX = 14'h3FFF;

    localparam logic [MARK_W-1:0] MARK_GOOD = 2'd0;
    localparam logic [MARK_W-1:0] MARK_WORN = 2'd1;
    localparam logic [MARK_W-1:0] MARK_RSVD = 2'd2;
    localparam logic [MARK_W-1:0] MARK_BAD  = 2'd3;

    localparam logic [BPB_W-1:0] BPB_RESET = 4'd2;
    localparam logic [TBL_W-1:0] TBL_RESET = 14'd8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BITS_PER_BLOCK = 2'd0,
        CFG_RESERVED_CODE  = 2'd1,
        CFG_BASE_GROUP     = 2'd2,
        CFG_TABLE_BLOCKS   = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef enum logic {
        CLR_SWEEP,
        CLR_DONE
    } clr_state_t;

    typedef struct packed {
        logic [BPB_W-1:0]  bits_per_block;
        logic [RSV_W-1:0]  reserved_code;
        logic [BASE_W-1:0] base_group;
        logic [TBL_W-1:0]  table_blocks;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  block_index;
        logic [MARK_W-1:0] add;
        logic [CNT_W-1:0]  bad_count;
        logic [CNT_W-1:0]  reserved_count;
        logic              last;
    } field_req_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? CNT_MAX : v + 14'd1;
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] field_mask(input logic [BPB_W-1:0] bpb);
        logic [BYTE_W-1:0] m;
        case (bpb)
            4'd1:    m = 8'h01;
            4'd2:    m = 8'h03;
            4'd4:    m = 8'h0F;
            4'd8:    m = 8'hFF;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic width_ok(input logic [BPB_W-1:0] bpb);
        logic ok;
        ok = (bpb == 4'd1) || (bpb == 4'd2) || (bpb == 4'd4) || (bpb == 4'd8);
        return ok;
    endfunction

endpackage

`default_nettype wire

// ----- src/bad_block_table_decoder_unit.sv -----
`default_nettype none

// Bad block table decoder. Each accepted table_byte is cut into fields of
// bits_per_block bits, low bits first; every field inside the table length and
// the store is merged into the 2-bit mark of its block and returns one word
// with the merged mark and the running bad and reserved counts, last set on
// the final word of the byte. The fields of a byte pass in turn through the
// mark memory read and the merge write-back, the single read-modify-write
// path of the mark memory, and a new byte is not taken until the last field
// of a byte has left the merge stage. A byte whose field width is not 1, 2, 4
// or 8 is taken and dropped. After reset the mark memory is cleared one entry
// a cycle, which holds in_stall high until every entry is cleared;
// configuration writes are taken at any time, with cfg_ready always high.
module bad_block_table_decoder_unit #(
    parameter int STORE_BLOCKS = bbtd_pkg::STORE_BLOCKS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bbtd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bbtd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [bbtd_pkg::BYTE_W-1:0]         table_byte,
    input  wire logic                                restart,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [bbtd_pkg::IDX_W-1:0]          block_index,
    output logic      [bbtd_pkg::MARK_W-1:0]         status,
    output logic      [bbtd_pkg::CNT_W-1:0]          bad_count,
    output logic      [bbtd_pkg::CNT_W-1:0]          reserved_count,
    output logic                                     last
);

    localparam int AW = $clog2(STORE_BLOCKS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BLOCKS - 1);

    bbtd_pkg::cfg_t          cfg_reg;
    bbtd_pkg::clr_state_t    clr_state_reg, clr_state_next;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    logic                    clearing;

    logic                          take;
    logic                          seq_busy;
    logic                          s2_pending;
    logic                          advance;
    bbtd_pkg::field_req_t          req;
    logic [AW-1:0]                 req_addr;
    logic [bbtd_pkg::MARK_W-1:0]   rd_data;
    logic                          m_wr_en;
    logic [AW-1:0]                 m_wr_addr;
    logic [bbtd_pkg::MARK_W-1:0]   m_wr_data;
    logic                          mem_wr_en;
    logic [AW-1:0]                 mem_wr_addr;
    logic [bbtd_pkg::MARK_W-1:0]   mem_wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bits_per_block <= bbtd_pkg::BPB_RESET;
            cfg_reg.reserved_code  <= '0;
            cfg_reg.base_group     <= '0;
            cfg_reg.table_blocks   <= bbtd_pkg::TBL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bbtd_pkg::cfg_reg_t'(cfg_index))
                bbtd_pkg::CFG_BITS_PER_BLOCK:
                    cfg_reg.bits_per_block <= cfg_data[bbtd_pkg::BPB_W-1:0];
                bbtd_pkg::CFG_RESERVED_CODE:
                    cfg_reg.reserved_code  <= cfg_data[bbtd_pkg::RSV_W-1:0];
                bbtd_pkg::CFG_BASE_GROUP:
                    cfg_reg.base_group     <= cfg_data[bbtd_pkg::BASE_W-1:0];
                bbtd_pkg::CFG_TABLE_BLOCKS:
                    cfg_reg.table_blocks   <= cfg_data[bbtd_pkg::TBL_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // sweep the mark memory to good after reset
    always_comb
    begin
        clr_state_next = clr_state_reg;
        clr_addr_next  = clr_addr_reg;
        clearing       = 1'b0;
        unique case (clr_state_reg)
            bbtd_pkg::CLR_SWEEP:
            begin
                clearing      = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_state_next = bbtd_pkg::CLR_DONE;
                end
            end
            bbtd_pkg::CLR_DONE:
            begin
                clearing = 1'b0;
            end
            default:
            begin
                clr_state_next = bbtd_pkg::CLR_SWEEP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_state_reg <= bbtd_pkg::CLR_SWEEP;
            clr_addr_reg  <= '0;
        end
        else
        begin
            clr_state_reg <= clr_state_next;
            clr_addr_reg  <= clr_addr_next;
        end
    end

    assign in_stall = clearing || seq_busy || s2_pending;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        if (clearing)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = bbtd_pkg::MARK_GOOD;
        end
        else
        begin
            mem_wr_en   = m_wr_en;
            mem_wr_addr = m_wr_addr;
            mem_wr_data = m_wr_data;
        end
    end

    bbtd_field_seq #(
        .STORE_BLOCKS (STORE_BLOCKS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .take       (take),
        .table_byte (table_byte),
        .restart    (restart),
        .advance    (advance),
        .busy       (seq_busy),
        .req        (req),
        .req_addr   (req_addr)
    );

    bbtd_mark_mem #(
        .STORE_BLOCKS (STORE_BLOCKS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (req.valid && advance),
        .rd_addr (req_addr),
        .rd_data (rd_data)
    );

    bbtd_merge #(
        .STORE_BLOCKS (STORE_BLOCKS)
    ) u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .req_addr       (req_addr),
        .rd_data        (rd_data),
        .out_stall      (out_stall),
        .advance        (advance),
        .pending        (s2_pending),
        .wr_en          (m_wr_en),
        .wr_addr        (m_wr_addr),
        .wr_data        (m_wr_data),
        .out_valid      (out_valid),
        .block_index    (block_index),
        .status         (status),
        .bad_count      (bad_count),
        .reserved_count (reserved_count),
        .last           (last)
    );

endmodule

`default_nettype wire

// ----- src/bbtd_mark_mem.sv -----
`default_nettype none

module bbtd_mark_mem #(
    parameter int STORE_BLOCKS = bbtd_pkg::STORE_BLOCKS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(STORE_BLOCKS)-1:0]   wr_addr,
    input  wire logic [bbtd_pkg::MARK_W-1:0]       wr_data,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(STORE_BLOCKS)-1:0]   rd_addr,
    output logic      [bbtd_pkg::MARK_W-1:0]       rd_data
);

    logic [bbtd_pkg::MARK_W-1:0] mem_array [STORE_BLOCKS];
    logic [bbtd_pkg::MARK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/bbtd_field_seq.sv -----
`default_nettype none

module bbtd_field_seq #(
    parameter int STORE_BLOCKS = bbtd_pkg::STORE_BLOCKS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bbtd_pkg::cfg_t                    cfg,
    input  wire logic                              take,
    input  wire logic [bbtd_pkg::BYTE_W-1:0]       table_byte,
    input  wire logic                              restart,
    input  wire logic                              advance,
    output logic                                   busy,
    output bbtd_pkg::field_req_t                   req,
    output logic      [$clog2(STORE_BLOCKS)-1:0]   req_addr
);

    localparam int AW = $clog2(STORE_BLOCKS);
    localparam logic [bbtd_pkg::WIDE_IDX_W-1:0] STORE_LIM =
        bbtd_pkg::WIDE_IDX_W'(STORE_BLOCKS);

    bbtd_pkg::seq_state_t              state_reg, state_next;
    logic [bbtd_pkg::BYTE_W-1:0]       shift_reg, shift_next;
    logic [bbtd_pkg::BPB_W-1:0]        bits_left_reg, bits_left_next;
    logic [bbtd_pkg::CNT_W-1:0]        counter_reg, counter_next;
    logic [bbtd_pkg::CNT_W-1:0]        bad_reg, bad_next;
    logic [bbtd_pkg::CNT_W-1:0]        rsv_reg, rsv_next;

    logic [bbtd_pkg::BYTE_W-1:0]       fmask;
    logic [bbtd_pkg::BYTE_W-1:0]       field;
    logic [bbtd_pkg::WIDE_IDX_W-1:0]   base_idx;
    logic [bbtd_pkg::WIDE_IDX_W-1:0]   idx;
    logic [bbtd_pkg::WIDE_IDX_W-1:0]   idx_n;
    logic [bbtd_pkg::CNT_W-1:0]        cnt_inc;
    logic                              keep;
    logic                              keep_n;
    logic                              final_field;
    logic                              is_good;
    logic                              is_rsv;
    logic [bbtd_pkg::MARK_W-1:0]       add;

    always_comb
    begin
        fmask       = bbtd_pkg::field_mask(cfg.bits_per_block);
        field       = shift_reg & fmask;
        base_idx    = {4'b0, cfg.base_group, 2'b00};
        idx         = base_idx + {3'b0, counter_reg};
        cnt_inc     = bbtd_pkg::sat_inc(counter_reg);
        idx_n       = base_idx + {3'b0, cnt_inc};
        keep        = (counter_reg < cfg.table_blocks) && (idx < STORE_LIM);
        keep_n      = (cnt_inc < cfg.table_blocks) && (idx_n < STORE_LIM);
        final_field = (bits_left_reg == cfg.bits_per_block);
        is_good     = (field == fmask);
        is_rsv      = !is_good && (cfg.reserved_code != 8'd0) && (field == cfg.reserved_code);
        if (is_good)
        begin
            add = bbtd_pkg::MARK_GOOD;
        end
        else if (is_rsv)
        begin
            add = bbtd_pkg::MARK_RSVD;
        end
        else if (field == 8'd0)
        begin
            add = bbtd_pkg::MARK_BAD;
        end
        else
        begin
            add = bbtd_pkg::MARK_WORN;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        counter_next   = counter_reg;
        bad_next       = bad_reg;
        rsv_next       = rsv_reg;
        unique case (state_reg)
            bbtd_pkg::SEQ_IDLE:
            begin
                if (take && bbtd_pkg::width_ok(cfg.bits_per_block))
                begin
                    state_next     = bbtd_pkg::SEQ_RUN;
                    shift_next     = table_byte;
                    bits_left_next = 4'd8;
                    counter_next   = restart ? '0 : counter_reg;
                end
            end
            bbtd_pkg::SEQ_RUN:
            begin
                if (advance)
                begin
                    if (keep && is_rsv)
                    begin
                        rsv_next = bbtd_pkg::sat_inc(rsv_reg);
                    end
                    else if (keep && !is_good)
                    begin
                        bad_next = bbtd_pkg::sat_inc(bad_reg);
                    end
                    shift_next     = shift_reg >> cfg.bits_per_block;
                    bits_left_next = bits_left_reg - cfg.bits_per_block;
                    counter_next   = cnt_inc;
                    if (final_field)
                    begin
                        state_next = bbtd_pkg::SEQ_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bbtd_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbtd_pkg::SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            bad_reg     <= '0;
            rsv_reg     <= '0;
        end
        else
        begin
            counter_reg <= counter_next;
            bad_reg     <= bad_next;
            rsv_reg     <= rsv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        bits_left_reg <= bits_left_next;
    end

    always_comb
    begin
        busy               = (state_reg == bbtd_pkg::SEQ_RUN);
        req.valid          = busy && keep;
        req.block_index    = idx[bbtd_pkg::IDX_W-1:0];
        req.add            = add;
        req.bad_count      = bad_next;
        req.reserved_count = rsv_next;
        req.last           = final_field || !keep_n;
        req_addr           = idx[AW-1:0];
    end

endmodule

`default_nettype wire

// ----- src/bbtd_merge.sv -----
`default_nettype none

module bbtd_merge #(
    parameter int STORE_BLOCKS = bbtd_pkg::STORE_BLOCKS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bbtd_pkg::field_req_t              req,
    input  wire logic [$clog2(STORE_BLOCKS)-1:0]   req_addr,
    input  wire logic [bbtd_pkg::MARK_W-1:0]       rd_data,
    input  wire logic                              out_stall,
    output logic                                   advance,
    output logic                                   pending,
    output logic                                   wr_en,
    output logic      [$clog2(STORE_BLOCKS)-1:0]   wr_addr,
    output logic      [bbtd_pkg::MARK_W-1:0]       wr_data,
    output logic                                   out_valid,
    output logic      [bbtd_pkg::IDX_W-1:0]        block_index,
    output logic      [bbtd_pkg::MARK_W-1:0]       status,
    output logic      [bbtd_pkg::CNT_W-1:0]        bad_count,
    output logic      [bbtd_pkg::CNT_W-1:0]        reserved_count,
    output logic                                   last
);

    localparam int AW = $clog2(STORE_BLOCKS);

    bbtd_pkg::field_req_t          s2_req_reg;
    logic [AW-1:0]                 s2_addr_reg;
    logic                          out_valid_reg;
    logic [bbtd_pkg::IDX_W-1:0]    block_index_reg;
    logic [bbtd_pkg::MARK_W-1:0]   status_reg;
    logic [bbtd_pkg::CNT_W-1:0]    bad_count_reg;
    logic [bbtd_pkg::CNT_W-1:0]    reserved_count_reg;
    logic                          last_reg;

    logic                          out_free;
    logic                          fire;
    logic [bbtd_pkg::MARK_W-1:0]   merged;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        advance  = !s2_req_reg.valid || out_free;
        fire     = s2_req_reg.valid && out_free;
        merged   = rd_data | s2_req_reg.add;
        pending  = s2_req_reg.valid;
        wr_en    = fire;
        wr_addr  = s2_addr_reg;
        wr_data  = merged;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_req_reg <= '0;
        end
        else if (advance)
        begin
            s2_req_reg <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_addr_reg <= req_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            block_index_reg    <= s2_req_reg.block_index;
            status_reg         <= merged;
            bad_count_reg      <= s2_req_reg.bad_count;
            reserved_count_reg <= s2_req_reg.reserved_count;
            last_reg           <= s2_req_reg.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign block_index    = block_index_reg;
    assign status         = status_reg;
    assign bad_count      = bad_count_reg;
    assign reserved_count = reserved_count_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

// ----- src/bad_block_table_decoder_unit_checker.sv -----
`default_nettype none

`include "bad_block_table_decoder_unit_macros.svh"

module bad_block_table_decoder_unit_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [bbtd_pkg::IDX_W-1:0]       block_index,
    input wire logic [bbtd_pkg::MARK_W-1:0]      status,
    input wire logic [bbtd_pkg::CNT_W-1:0]       bad_count,
    input wire logic [bbtd_pkg::CNT_W-1:0]       reserved_count,
    input wire logic                             last
);

    logic [bbtd_pkg::CNT_W-1:0] prev_bad_reg;
    logic [bbtd_pkg::CNT_W-1:0] prev_rsv_reg;
    logic [bbtd_pkg::CNT_W:0]   prev_sum_reg;
    logic [bbtd_pkg::CNT_W:0]   cur_sum;
    logic [bbtd_pkg::CNT_W+1:0] sum_limit;

    assign cur_sum   = {1'b0, bad_count} + {1'b0, reserved_count};
    assign sum_limit = {1'b0, prev_sum_reg} + 16'd1;

    // track the counts of the last word taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bad_reg <= '0;
            prev_rsv_reg <= '0;
            prev_sum_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            prev_bad_reg <= bad_count;
            prev_rsv_reg <= reserved_count;
            prev_sum_reg <= cur_sum;
        end
    end

    `BBTD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(block_index) && $stable(status) && $stable(bad_count) &&
        $stable(reserved_count) && $stable(last))
    `BBTD_ASSERT_NOW(a_counts_grow, out_valid,
        (bad_count >= prev_bad_reg) && (reserved_count >= prev_rsv_reg))
    `BBTD_ASSERT_NOW(a_counts_step, out_valid, {1'b0, cur_sum} <= sum_limit)
    `BBTD_ASSERT_NOW(a_good_no_count, out_valid && (status == bbtd_pkg::MARK_GOOD),
        (bad_count == prev_bad_reg) && (reserved_count == prev_rsv_reg))

endmodule

bind bad_block_table_decoder_unit bad_block_table_decoder_unit_checker u_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int STORE_N       = bbtd_pkg::STORE_BLOCKS_DEF;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_NS      = 8_000_000;

    typedef struct packed {
        logic [bbtd_pkg::IDX_W-1:0]  block_index;
        logic [bbtd_pkg::MARK_W-1:0] status;
        logic [bbtd_pkg::CNT_W-1:0]  bad_count;
        logic [bbtd_pkg::CNT_W-1:0]  reserved_count;
        logic                        last;
    } mark_word_t;

    class mark_checker;
        logic [bbtd_pkg::MARK_W-1:0] marks [STORE_N];
        int unsigned       block_ctr;
        int unsigned       bad_tot;
        int unsigned       rsv_tot;
        int unsigned       bpb;
        int unsigned       rsv_code;
        int unsigned       base;
        int unsigned       tbl_len;
        mark_word_t        pending_marks [$];
        int                errors;

        function new();
            foreach (marks[i])
                marks[i] = bbtd_pkg::MARK_GOOD;
            block_ctr = 0;
            bad_tot   = 0;
            rsv_tot   = 0;
            bpb       = bbtd_pkg::BPB_RESET;
            rsv_code  = 0;
            base      = 0;
            tbl_len   = bbtd_pkg::TBL_RESET;
            errors    = 0;
        endfunction

        static function bit width_in_use(input int unsigned w);
            return (w == 1) || (w == 2) || (w == 4) || (w == 8);
        endfunction

        static function int unsigned bump(input int unsigned v);
            return (v < bbtd_pkg::CNT_MAX) ? v + 1 : bbtd_pkg::CNT_MAX;
        endfunction

        function void set_reg(input bbtd_pkg::cfg_reg_t r, input int unsigned v);
            case (r)
                bbtd_pkg::CFG_BITS_PER_BLOCK: bpb      = v & 32'hF;
                bbtd_pkg::CFG_RESERVED_CODE:  rsv_code = v & 32'hFF;
                bbtd_pkg::CFG_BASE_GROUP:     base     = v & 32'h7FF;
                bbtd_pkg::CFG_TABLE_BLOCKS:   tbl_len  = v & 32'h3FFF;
                default: ;
            endcase
        endfunction

        function void decode_byte(input logic [7:0] b, input logic rs);
            int unsigned                 fmask;
            int unsigned                 f;
            int unsigned                 idx;
            int unsigned                 pos;
            int                          first;
            logic [bbtd_pkg::MARK_W-1:0] add;
            mark_word_t                  w;
            if (!width_in_use(bpb))
                return;
            if (rs)
                block_ctr = 0;
            fmask = (1 << bpb) - 1;
            first = pending_marks.size();
            for (pos = 0; pos < 8; pos += bpb)
            begin
                f   = (b >> pos) & fmask;
                idx = base * 4 + block_ctr;
                if (block_ctr < tbl_len && idx < STORE_N)
                begin
                    if (f == fmask)
                        add = bbtd_pkg::MARK_GOOD;
                    else if (rsv_code != 0 && f == rsv_code)
                    begin
                        add     = bbtd_pkg::MARK_RSVD;
                        rsv_tot = bump(rsv_tot);
                    end
                    else
                    begin
                        add     = (f == 0) ? bbtd_pkg::MARK_BAD : bbtd_pkg::MARK_WORN;
                        bad_tot = bump(bad_tot);
                    end
                    marks[idx]       = marks[idx] | add;
                    w.block_index    = idx[bbtd_pkg::IDX_W-1:0];
                    w.status         = marks[idx];
                    w.bad_count      = bad_tot[bbtd_pkg::CNT_W-1:0];
                    w.reserved_count = rsv_tot[bbtd_pkg::CNT_W-1:0];
                    w.last           = 1'b0;
                    pending_marks.push_back(w);
                end
                block_ctr = bump(block_ctr);
            end
            if (pending_marks.size() > first)
                pending_marks[pending_marks.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_mark(input mark_word_t got);
            mark_word_t want;
            if (pending_marks.size() == 0)
            begin
                $display("%0t: unexpected word, expected none got %p", $time, got);
                errors++;
                return;
            end
            want = pending_marks.pop_front();
            compare_field("block_index", 32'(want.block_index), 32'(got.block_index));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("bad_count", 32'(want.bad_count), 32'(got.bad_count));
            compare_field("reserved_count", 32'(want.reserved_count),
                          32'(got.reserved_count));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction

        function int outstanding();
            return pending_marks.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [bbtd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bbtd_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [bbtd_pkg::BYTE_W-1:0]     table_byte;
    logic                            restart;
    logic                            out_valid;
    logic                            out_stall;
    logic [bbtd_pkg::IDX_W-1:0]      block_index;
    logic [bbtd_pkg::MARK_W-1:0]     status;
    logic [bbtd_pkg::CNT_W-1:0]      bad_count;
    logic [bbtd_pkg::CNT_W-1:0]      reserved_count;
    logic                            last;

    mark_checker board;
    bit          idle_on;
    bit          long_hold_req;

    bad_block_table_decoder_unit #(
        .STORE_BLOCKS(STORE_N)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .table_byte     (table_byte),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .block_index    (block_index),
        .status         (status),
        .bad_count      (bad_count),
        .reserved_count (reserved_count),
        .last           (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] table_content(input int unsigned w, input int unsigned code);
        logic [7:0]  b;
        int unsigned fmax;
        int unsigned pos;
        int unsigned f;
        b = 8'($urandom);
        if (!mark_checker::width_in_use(w) || $urandom_range(0, 4) == 0)
            return b;
        b    = 8'h00;
        fmax = (1 << w) - 1;
        for (pos = 0; pos < 8; pos += w)
        begin
            case ($urandom_range(0, 3))
                0:       f = 0;
                1:       f = fmax;
                2:       f = code & fmax;
                default: f = $urandom & fmax;
            endcase
            b = b | 8'(f << pos);
        end
        return b;
    endfunction

    initial
    begin : receiver
        int k;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                k = pick_len();
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            board.check_mark({block_index, status, bad_count, reserved_count, last});
    end

    task automatic send_byte(input logic [7:0] b, input logic rs);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        table_byte <= b;
        restart    <= rs;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        board.decode_byte(b, rs);
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input bbtd_pkg::cfg_reg_t r, input int unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v[bbtd_pkg::CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        board.set_reg(r, v);
    endtask

    task automatic configure(input int unsigned bpb, input int unsigned rsv,
                             input int unsigned base, input int unsigned tbl);
        put_reg(bbtd_pkg::CFG_BITS_PER_BLOCK, bpb);
        put_reg(bbtd_pkg::CFG_RESERVED_CODE, rsv);
        put_reg(bbtd_pkg::CFG_BASE_GROUP, base);
        put_reg(bbtd_pkg::CFG_TABLE_BLOCKS, tbl);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_part();
        // reset settings, then store end, empty table, short table, code edges
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE4, 1'b0);
        drain_and_settle();
        configure(8, 8'hA5, 2047, 16383);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h37, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain_and_settle();
        configure(1, 1, 0, 0);
        send_byte(8'h5A, 1'b1);
        drain_and_settle();
        configure(1, 1, 5, 3);
        send_byte(8'h0F, 1'b1);
        send_byte(8'h00, 1'b0);
        drain_and_settle();
        configure(4, 5, 0, 8192);
        send_byte(8'h5F, 1'b1);
        send_byte(8'h05, 1'b0);
        drain_and_settle();
        configure(4, 8'h1F, 1, 8192);
        send_byte(8'hF1, 1'b1);
        send_byte(8'h50, 1'b0);
        drain_and_settle();
        configure(2, 3, 0, 8192);
        send_byte(8'hC3, 1'b1);
        drain_and_settle();
        configure(3, 0, 0, 8192);
        send_byte(8'h00, 1'b1);
        drain_and_settle();
        configure(15, 8'hFF, 0, 8192);
        send_byte(8'h81, 1'b1);
        drain_and_settle();
        configure(2, 2, 0, 8192);
        send_byte(8'hAA, 1'b1);
    endtask

    task automatic random_setup();
        int unsigned bpb;
        int unsigned rsv;
        int unsigned base;
        int unsigned tbl;
        int unsigned fmax;
        if ($urandom_range(0, 9) < 8)
            bpb = 1 << $urandom_range(0, 3);
        else
            bpb = $urandom_range(0, 15);
        fmax = mark_checker::width_in_use(bpb) ? (1 << bpb) - 1 : 255;
        case ($urandom_range(0, 3))
            0:       rsv = 0;
            1:       rsv = $urandom_range(1, fmax);
            2:       rsv = $urandom_range(0, 255);
            default: rsv = 255;
        endcase
        case ($urandom_range(0, 2))
            0:       base = 0;
            1:       base = $urandom_range(0, 64);
            default: base = $urandom_range(2040, 2047);
        endcase
        case ($urandom_range(0, 3))
            0:       tbl = 8192;
            1:       tbl = $urandom_range(1, 48);
            2:       tbl = 16383;
            default: tbl = $urandom_range(1, 16383);
        endcase
        configure(bpb, rsv, base, tbl);
    endtask

    task automatic random_phase(input int p);
        int counted;
        int sent;
        int len;
        int k;
        counted = 0;
        sent    = 0;
        while (counted < 22 && sent < 40)
        begin
            if (p == 2 && counted == 15)
                drain_and_settle();
            // mostly whole tables, some stray bytes with random restart
            if ($urandom_range(0, 9) < 8)
                len = $urandom_range(1, 12);
            else
                len = $urandom_range(1, 3);
            for (k = 0; k < len; k++)
            begin
                if (len > 3 || $urandom_range(0, 1) == 0)
                    send_byte(table_content(board.bpb, board.rsv_code), k == 0);
                else
                    send_byte(table_content(board.bpb, board.rsv_code),
                              1'($urandom_range(0, 1)));
                sent++;
                if (mark_checker::width_in_use(board.bpb))
                    counted++;
            end
        end
    endtask

    initial
    begin : stimulus
        int p;
        board         = new();
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = bbtd_pkg::CFG_BITS_PER_BLOCK;
        cfg_data      = '0;
        in_valid      = 1'b0;
        table_byte    = '0;
        restart       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        directed_part();

        for (p = 0; p < 6; p++)
        begin
            drain_and_settle();
            if (p == 1)
                configure(2, 1, 0, 8192);
            else
                random_setup();
            idle_on = (p == 1) ? 1'b0 : (p == 4) ? 1'b0 : 1'b1;
            if (p == 1)
                long_hold_req = 1'b1;
            random_phase(p);
        end

        drain_and_settle();
        if (board.errors == 0)
            $display("bad_block_table_decoder_unit: match");
        else
            $display("bad_block_table_decoder_unit: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #LIMIT_NS;
        $display("bad_block_table_decoder_unit: mismatch");
        $finish;
    end

endmodule
